[hw/rtl/spq_pkg.sv]
package spq_pkg;

    // Queue depth and the widths that follow from it.
    localparam int CAPACITY = 16;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 16;
    localparam int STATUS_W = 2;

    // Operation codes carried in the input tuser.
    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } action_t;

    // Result status codes carried in the output tuser.
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_REMOVED   = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // One stored queue entry.
    typedef struct packed {
        logic signed [PRIO_W-1:0]  prio;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

endpackage

[hw/rtl/sorted_priority_queue_unit.sv]
// Sorted priority queue of CAPACITY entries held in one single-port-read RAM,
// head at address 0. Each request on the s_ channel (tuser = operation) gives
// exactly one result on the m_ channel (tuser = status). A single comparator and
// the RAM's one read and one write port are stepped by a small sequencer, so one
// request is handled at a time and s_tready is low while it runs. An insert walks
// from the tail toward the head, moving each entry with a larger priority number
// one place back, and then writes the new entry into the gap. A remove reads the
// head and then slides the remaining n - 1 entries forward one per cycle. The RAM
// read port is registered, and each result waits in the output register until it
// is taken. No clearing pass runs after reset.
module sorted_priority_queue_unit
    import spq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] item_value, [47:32] item_priority
    input  logic [0:0]  s_tuser,   // [0] action

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] removed_value
    output logic [1:0]  m_tuser    // [1:0] status
);

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_INS_CMP   = 6'b000010,
        S_INS_PUT   = 6'b000100,
        S_REM_HEAD  = 6'b001000,
        S_REM_SHIFT = 6'b010000,
        S_RESP      = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    entry_t            new_reg, new_next;
    logic [VALUE_W-1:0] res_value_reg, res_value_next;
    status_t           res_status_reg, res_status_next;

    logic              m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0] m_value_reg, m_value_next;
    status_t           m_status_reg, m_status_next;

    // Queue storage with a registered read port.
    entry_t            mem [CAPACITY];
    entry_t            rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;

    logic              in_fire;
    logic              out_free;
    entry_t            in_entry;
    logic [CNT_W-1:0]  count_dec;

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_status_reg;

    assign in_entry.value = s_tdata[31:0];
    assign in_entry.prio  = s_tdata[47:32];
    assign count_dec      = count_reg - CNT_W'(1);

    // RAM write and read ports.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Sequencer: search and shift one entry per cycle.
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        new_next        = new_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_value_next    = m_value_reg;
        m_status_next   = m_status_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = new_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    new_next       = in_entry;
                    res_value_next = '0;
                    state_next     = S_RESP;
                    if (s_tuser[0] == ACT_INSERT) begin
                        if (count_reg >= CNT_W'(CAPACITY)) begin
                            res_status_next = ST_FULL;
                        end else if (count_reg == '0) begin
                            // Empty queue: the new entry becomes the head.
                            wr_en           = 1'b1;
                            wr_addr         = '0;
                            wr_data         = in_entry;
                            count_next      = CNT_W'(1);
                            res_status_next = ST_INSERTED;
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = ADDR_W'(count_dec);
                            idx_next   = ADDR_W'(count_reg);
                            state_next = S_INS_CMP;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            res_status_next = ST_UNDERFLOW;
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            state_next = S_REM_HEAD;
                        end
                    end
                end
            end

            S_INS_CMP: begin
                // The entry just read sits at idx - 1.
                if (rd_data_reg.prio > new_reg.prio) begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg;
                    wr_data = rd_data_reg;
                    if (idx_reg == ADDR_W'(1)) begin
                        idx_next   = '0;
                        state_next = S_INS_PUT;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg - ADDR_W'(2);
                        idx_next = idx_reg - ADDR_W'(1);
                    end
                end else begin
                    wr_en           = 1'b1;
                    wr_addr         = idx_reg;
                    wr_data         = new_reg;
                    count_next      = count_reg + CNT_W'(1);
                    res_status_next = ST_INSERTED;
                    state_next      = S_RESP;
                end
            end

            S_INS_PUT: begin
                wr_en           = 1'b1;
                wr_addr         = idx_reg;
                wr_data         = new_reg;
                count_next      = count_reg + CNT_W'(1);
                res_status_next = ST_INSERTED;
                state_next      = S_RESP;
            end

            S_REM_HEAD: begin
                res_value_next  = rd_data_reg.value;
                res_status_next = ST_REMOVED;
                if (count_reg == CNT_W'(1)) begin
                    count_next = count_dec;
                    state_next = S_RESP;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = ADDR_W'(1);
                    idx_next   = ADDR_W'(1);
                    state_next = S_REM_SHIFT;
                end
            end

            S_REM_SHIFT: begin
                // Move the entry read from idx one place toward the head.
                wr_en   = 1'b1;
                wr_addr = idx_reg - ADDR_W'(1);
                wr_data = rd_data_reg;
                if (CNT_W'(idx_reg) == count_dec) begin
                    count_next = count_dec;
                    state_next = S_RESP;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + ADDR_W'(1);
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end

            S_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_value_next  = res_value_reg;
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        new_reg        <= new_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_value_reg    <= m_value_next;
        m_status_reg   <= m_status_next;
    end

endmodule

[dv/sorted_priority_queue_unit_test.sv]
`timescale 1ns / 1ps

module sorted_priority_queue_unit_test;
    import spq_pkg::*;

    localparam int RANDOM_REQUESTS = 1950;
    localparam int RANDOM_CHUNKS   = 4;
    localparam int SETTLE_CYCLES   = CAPACITY + 10;
    localparam int MAX_REPORTS     = 10;

    // One queue request as it travels on the input channel.
    typedef struct packed {
        action_t            act;
        logic [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]  prio;
    } request_t;

    // One reply as it should appear on the output channel.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        status_t            status;
    } reply_t;

    // Ways in which the receiver holds off replies.
    typedef enum int {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_PERIODIC,
        READY_SPARSE
    } stall_pattern_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // [31:0] item_value, [47:32] item_priority
    logic [0:0]  s_tuser  = '0;   // [0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [31:0] removed_value
    logic [1:0]  m_tuser;         // [1:0] status

    // Our own copy of the sorted queue, head at index zero.
    logic [VALUE_W-1:0]       queued_value [CAPACITY];
    logic signed [PRIO_W-1:0] queued_prio  [CAPACITY];
    int                       queue_fill = 0;

    request_t request_backlog [$];
    reply_t   expected_replies [$];
    request_t on_bus;
    int       requests_queued = 0;
    int       requests_taken  = 0;
    int       mismatch_count  = 0;

    int             burst_left  = 1;
    int             gap_left    = 0;
    stall_pattern_t stall_mode  = READY_ALWAYS;
    int             mode_cycles = 0;
    int             cycle_count = 0;

    sorted_priority_queue_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Apply one accepted request to the queue copy and record the reply it earns.
    function automatic void predict_reply(input request_t req);
        reply_t rep;
        int     pos;
        int     i;
        rep.value  = '0;
        rep.status = ST_INSERTED;
        if (req.act == ACT_INSERT) begin
            if (queue_fill >= CAPACITY) begin
                rep.status = ST_FULL;
            end else begin
                // The new entry goes behind every entry of equal or smaller number.
                pos = 0;
                while (pos < queue_fill && queued_prio[pos] <= $signed(req.prio)) begin
                    pos++;
                end
                for (i = queue_fill; i > pos; i--) begin
                    queued_value[i] = queued_value[i-1];
                    queued_prio[i]  = queued_prio[i-1];
                end
                queued_value[pos] = req.value;
                queued_prio[pos]  = $signed(req.prio);
                queue_fill++;
            end
        end else if (queue_fill == 0) begin
            rep.status = ST_UNDERFLOW;
        end else begin
            rep.value  = queued_value[0];
            rep.status = ST_REMOVED;
            for (i = 1; i < queue_fill; i++) begin
                queued_value[i-1] = queued_value[i];
                queued_prio[i-1]  = queued_prio[i];
            end
            queue_fill--;
        end
        expected_replies.push_back(rep);
    endfunction

    function automatic void add_request(input action_t act, input logic [VALUE_W-1:0] value,
                                        input logic [PRIO_W-1:0] prio);
        request_t req;
        req.act   = act;
        req.value = value;
        req.prio  = prio;
        request_backlog.push_back(req);
        requests_queued++;
    endfunction

    // Random requests in runs that lean toward inserts, removes or neither,
    // so the queue swings between empty and full many times.
    task automatic add_random_requests(input int count);
        int          insert_pct;
        int          run;
        int          i;
        logic [31:0] value;
        logic [15:0] prio;
        insert_pct = 50;
        run = 0;
        for (i = 0; i < count; i++) begin
            if (run == 0) begin
                run = $urandom_range(20, 60);
                case ($urandom_range(0, 2))
                    0: insert_pct = 15;
                    1: insert_pct = 50;
                    default: insert_pct = 85;
                endcase
            end
            run--;
            value = ($urandom_range(0, 15) == 0) ?
                    ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000) : $urandom;
            // A narrow band around zero makes equal priorities common.
            case ($urandom_range(0, 9))
                0, 1, 2, 3: prio = 16'($urandom_range(0, 4)) - 16'd2;
                4: prio = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                default: prio = 16'($urandom);
            endcase
            add_request(($urandom_range(1, 100) <= insert_pct) ? ACT_INSERT : ACT_REMOVE,
                        value, prio);
        end
    endtask

    task automatic wait_for_drain();
        while (requests_taken != requests_queued || expected_replies.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_reply(on_bus);
                requests_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 || request_backlog.size() == 0) begin
                    if (gap_left > 0) begin
                        gap_left--;
                    end
                    s_tvalid <= 1'b0;
                end else begin
                    on_bus = request_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {on_bus.prio, on_bus.value};
                    s_tuser  <= on_bus.act;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                    end
                end
            end
        end
    end

    // Reply monitor and receiver stall pattern.
    always @(posedge aclk) begin
        reply_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_replies.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("unexpected reply: value %h status %0d", m_tdata, m_tuser);
                    end
                end else begin
                    want = expected_replies.pop_front();
                    if (m_tdata !== want.value || m_tuser !== want.status) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("reply mismatch: expected value %h status %0d, got %h %0d",
                                     want.value, want.status, m_tdata, m_tuser);
                        end
                    end
                end
            end

            // Switch to a new stall pattern every so often.
            if (mode_cycles == 0) begin
                stall_mode  = stall_pattern_t'($urandom_range(0, 3));
                mode_cycles = $urandom_range(64, 256);
            end
            mode_cycles--;
            cycle_count++;
            case (stall_mode)
                READY_ALWAYS:   m_tready <= 1'b1;
                READY_MOSTLY:   m_tready <= ($urandom_range(0, 3) != 0);
                READY_PERIODIC: m_tready <= (cycle_count[2:0] > 3'd2);
                default:        m_tready <= ($urandom_range(0, 2) == 0);
            endcase
        end
    end

    initial begin
        int i;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: underflow, fill with extreme and equal priorities,
        // a refused insert when full, then a few removes from the head.
        add_request(ACT_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
        add_request(ACT_INSERT, 32'h7FFF_FFFF, 16'h7FFF);
        add_request(ACT_INSERT, 32'h8000_0000, 16'h8000);
        add_request(ACT_INSERT, 32'h0000_0000, 16'h0000);
        add_request(ACT_INSERT, 32'hFFFF_FFFF, 16'h0000);
        add_request(ACT_INSERT, 32'h0000_0001, 16'h0000);
        add_request(ACT_INSERT, 32'h5555_5555, 16'hFFFF);
        add_request(ACT_INSERT, 32'hAAAA_AAAA, 16'h0001);
        add_request(ACT_INSERT, 32'h1234_5678, 16'h7FFF);
        add_request(ACT_INSERT, 32'hDEAD_BEEF, 16'h8000);
        for (i = 0; i < CAPACITY - 9; i++) begin
            add_request(ACT_INSERT, 32'h0F0F_0000 + i, 16'h4000 - 16'(i));
        end
        add_request(ACT_INSERT, 32'h7FFF_FFFF, 16'h8000);
        for (i = 0; i < 4; i++) begin
            add_request(ACT_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
        end

        // Hold the sender until every directed reply is back.
        wait_for_drain();

        for (i = 0; i < RANDOM_CHUNKS; i++) begin
            add_random_requests(RANDOM_REQUESTS / RANDOM_CHUNKS);
            wait_for_drain();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_replies.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
